// ===== src/bcjenc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcjenc_pkg
// Shared types and constants for the x86 branch converter (encode side).
// ----------------------------------------------------------------------------
package bcjenc_pkg;

   localparam int WinLen     = 5;
   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   localparam logic [7:0] OpCall = 8'hE8;
   localparam logic [7:0] OpJump = 8'hE9;

   // Up to five result bytes produced by one input item
   typedef struct packed {
      logic [WinLen-1:0][7:0] bytes;
      logic [WinLen-1:0]      exam;
      logic [2:0]             cnt;
      logic                   last;
   } bundle_type;

endpackage

// ===== src/bcjenc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcjenc_front
// Accepts stream bytes, keeps the lookahead window and opcode history,
// classifies the head byte and runs the displacement conversion. An item
// that fills the window or ends the stream yields one result bundle for the queue.
// ----------------------------------------------------------------------------
module bcjenc_front import bcjenc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        q_full,
   output logic        q_push,
   output bundle_type  q_data
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StAdd  = 2'd1;
   localparam logic [1:0] StConv = 2'd2;
   localparam logic [1:0] StPush = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [7:0]  win_ff [WinLen];
   logic [7:0]  win_in [WinLen];
   logic [2:0]  fill_ff, fill_in;
   logic [31:0] head_ff, head_in;
   logic [2:0]  dist_ff, dist_in;
   logic [7:0]  pmask_ff, pmask_in;
   logic        last_ff, last_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] add_ff, add_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dest_ff, dest_in;
   logic [1:0]  iter_ff, iter_in;

   logic [7:0]  win_w [WinLen];
   logic [2:0]  new_fill;
   logic        full_w;
   logic        is_op;
   logic [7:0]  pm_sh;
   logic        qual;
   logic        conv;
   logic        accept;
   logic [31:0] dest_w;
   logic [1:0]  bsel;
   logic [7:0]  chk_byte;
   logic [31:0] lmask;
   logic        again;

   function automatic logic ms_byte(input logic [7:0] b);
      return (b == 8'h00) || (b == 8'hFF);
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == StIdle) && !q_full;
   assign accept     = req_tvalid && req_tready;

   // Byte lane checked during re-conversion, picked by the shifted mask
   always_comb begin
      case (pmask_ff[7:1])
         7'd0:    bsel = 2'd0;
         7'd1:    bsel = 2'd1;
         7'd2:    bsel = 2'd2;
         7'd3:    bsel = 2'd2;
         7'd4:    bsel = 2'd3;
         default: bsel = 2'd0;
      endcase
   end

   always_comb begin
      dest_w = src_ff + add_ff;
      case (bsel)
         2'd0:    begin chk_byte = dest_w[31:24]; lmask = 32'hFFFF_FFFF; end
         2'd1:    begin chk_byte = dest_w[23:16]; lmask = 32'h00FF_FFFF; end
         2'd2:    begin chk_byte = dest_w[15:8];  lmask = 32'h0000_FFFF; end
         default: begin chk_byte = dest_w[7:0];   lmask = 32'h0000_00FF; end
      endcase
      again = (iter_ff < 2'd2) && (pmask_ff != 8'h00) && ms_byte(chk_byte);
   end

   // Window with the incoming byte placed, and head classification
   always_comb begin
      win_w = win_ff;
      win_w[fill_ff] = req_tdata;
      new_fill = fill_ff + 3'd1;
      full_w   = (new_fill == 3'(WinLen));
      is_op    = (win_w[0] == OpCall) || (win_w[0] == OpJump);
      pm_sh    = pmask_ff;
      for (int k = 0; k < WinLen; k++) begin
         if (3'(k) < dist_ff) begin
            pm_sh = {pm_sh[6:0] & 7'h77, 1'b0};
         end
      end
      if (dist_ff > 3'd5) begin
         pm_sh = 8'h00;
      end
      qual = ms_byte(win_w[4]) && (pm_sh[7:1] <= 7'd4) && (pm_sh[7:1] != 7'd3);
      conv = full_w && is_op && qual;
   end

   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      fill_in  = fill_ff;
      head_in  = head_ff;
      dist_in  = dist_ff;
      pmask_in = pmask_ff;
      last_in  = last_ff;
      start_in = csr_valid ? csr_data : start_ff;
      add_in   = add_ff;
      src_in   = src_ff;
      dest_in  = dest_ff;
      iter_in  = iter_ff;
      q_push   = 1'b0;
      q_data   = '0;

      case (state_ff)
         StIdle: begin
            for (int k = 0; k < WinLen; k++) begin
               q_data.bytes[k] = win_w[k];
            end
            q_data.last = req_tlast;
            if (full_w) begin
               q_data.exam = 5'b00001;
               q_data.cnt  = req_tlast ? 3'(WinLen) : 3'd1;
            end else begin
               q_data.cnt  = req_tlast ? new_fill : 3'd0;
            end
            if (accept) begin
               win_in  = win_w;
               fill_in = new_fill;
               if (conv) begin
                  pmask_in = pm_sh;
                  last_in  = req_tlast;
                  state_in = StAdd;
               end else begin
                  q_push = (q_data.cnt != 3'd0);
                  if (full_w) begin
                     // drop the examined head byte
                     for (int k = 0; k < WinLen - 1; k++) begin
                        win_in[k] = win_w[k + 1];
                     end
                     fill_in = 3'(WinLen - 1);
                     head_in = head_ff + 32'd1;
                     if (is_op) begin
                        dist_in  = 3'd1;
                        pmask_in = pm_sh | 8'h01 | (ms_byte(win_w[4]) ? 8'h10 : 8'h00);
                     end else if (dist_ff < 3'd6) begin
                        dist_in = dist_ff + 3'd1;
                     end
                  end
                  if (req_tlast) begin
                     fill_in  = 3'd0;
                     head_in  = 32'd0;
                     dist_in  = 3'd5;
                     pmask_in = 8'h00;
                  end
               end
            end
         end
         StAdd: begin
            add_in   = start_ff + head_ff + 32'd5;
            src_in   = {win_ff[4], win_ff[3], win_ff[2], win_ff[1]};
            iter_in  = 2'd0;
            state_in = StConv;
         end
         StConv: begin
            if (again) begin
               src_in  = dest_w ^ lmask;
               iter_in = iter_ff + 2'd1;
            end else begin
               dest_in  = dest_w;
               state_in = StPush;
            end
         end
         StPush: begin
            q_data.bytes[0] = win_ff[0];
            q_data.bytes[1] = dest_ff[7:0];
            q_data.bytes[2] = dest_ff[15:8];
            q_data.bytes[3] = dest_ff[23:16];
            q_data.bytes[4] = dest_ff[24] ? 8'hFF : 8'h00;
            q_data.exam     = '1;
            q_data.cnt      = 3'(WinLen);
            q_data.last     = last_ff;
            if (!q_full) begin
               q_push   = 1'b1;
               fill_in  = 3'd0;
               head_in  = last_ff ? 32'd0 : head_ff + 32'd5;
               dist_in  = 3'd5;
               pmask_in = 8'h00;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         fill_ff  <= 3'd0;
         head_ff  <= 32'd0;
         dist_ff  <= 3'd5;
         pmask_ff <= 8'h00;
         start_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         dist_ff  <= dist_in;
         pmask_ff <= pmask_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      last_ff <= last_in;
      add_ff  <= add_in;
      src_ff  <= src_in;
      dest_ff <= dest_in;
      iter_ff <= iter_in;
   end

endmodule

// ===== src/bcjenc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcjenc_queue
// Short FIFO of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
module bcjenc_queue import bcjenc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       valid,
   output bundle_type head
);

   bundle_type       mem_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;

   assign full  = (count_ff == QCntW'(QueueDepth));
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/bcjenc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcjenc_back
// Walks each queued bundle and drives its bytes one by one into the
// registered result port.
// ----------------------------------------------------------------------------
module bcjenc_back import bcjenc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  bundle_type q_data,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   logic       vld_ff, vld_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       exam_ff, exam_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_w;

   assign load    = q_valid && (!vld_ff || rsp_tready);
   assign final_w = (idx_ff == q_data.cnt - 3'd1);
   assign q_pop   = load && final_w;

   always_comb begin
      vld_in  = vld_ff;
      idx_in  = idx_ff;
      byte_in = byte_ff;
      exam_in = exam_ff;
      last_in = last_ff;
      if (load) begin
         vld_in  = 1'b1;
         byte_in = q_data.bytes[idx_ff];
         exam_in = q_data.exam[idx_ff];
         last_in = q_data.last && final_w;
         idx_in  = final_w ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      exam_ff <= exam_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = exam_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== src/x86_branch_convert_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_branch_convert_encoder
// Timing: a plain byte's results pass through the queue entry and the output
//   register; a CALL/JMP conversion adds the address add, 1 to 3 passes of the
//   32-bit re-conversion adder and the queue push, and holds the input meanwhile.
// Throughput: otherwise one byte per cycle while results fit the output; a
//   five-byte result bundle leaves one byte at a time, a two-entry queue
//   absorbs the difference. Synchronous active-high reset clears the stream.
// ----------------------------------------------------------------------------
module x86_branch_convert_encoder import bcjenc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,    // start_position
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] examined
   output logic        rsp_tlast    // out_last
);

   logic       q_full;
   logic       q_push;
   bundle_type q_in;
   logic       q_pop;
   logic       q_valid;
   bundle_type q_head;

   bcjenc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   bcjenc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   bcjenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
